// ----- rtl/trimmed_burst_moving_average_assert.svh -----
// Assertion macros shared by the checker of the trimmed burst moving average
`ifndef TRIMMED_BURST_MOVING_AVERAGE_ASSERT_SVH
`define TRIMMED_BURST_MOVING_AVERAGE_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted
`define TBMA_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tbma check failed");

// Next-cycle implication, ignored while reset is asserted
`define TBMA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tbma check failed");

// Next-cycle implication that also holds across reset
`define TBMA_ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("tbma check failed");

`endif

// ----- rtl/tbma_pkg.sv -----
// Shared constants and types of the trimmed burst moving average
`default_nettype none

package tbma_pkg;

    // Parameter defaults
    localparam int DEF_WINDOW_DEPTH = 16;
    localparam int DEF_MAX_BURST    = 64;
    localparam int DEF_SAMPLE_BITS  = 12;

    // Fixed port widths
    localparam int SAMPLE_W  = 12;
    localparam int LEN_W     = 7;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 1;

    // Register map and burst rules
    localparam logic [REG_IDX_W-1:0] REG_BURST_LEN = 1'b0;
    localparam logic [LEN_W-1:0]     LEN_RESET     = 7'd10;
    localparam int                   MIN_BURST     = 3;
    localparam int                   TRIM_COUNT    = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MEAN_START,
        ST_MEAN_WAIT,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/tbma_ram.sv -----
// Generic single-port-write, registered-read RAM
`default_nettype none

module tbma_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wen,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_ren,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held between reads
    always_ff @(posedge i_clk) begin
        if (i_ren) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/tbma_div.sv -----
// Restoring divider, one quotient bit per cycle
`default_nettype none

module tbma_div #(
    parameter int NW = 20,
    parameter int DW = 7,
    parameter int QW = 12
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_dividend,
    input  wire logic [DW-1:0] i_divisor,
    output logic               o_done,
    output logic      [QW-1:0] o_quotient
);

    localparam int CW   = (NW > DW + QW) ? NW : DW + QW;
    localparam int CntW = $clog2(QW);

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic [CW-1:0]   r_rem, n_rem;
    logic [CW-1:0]   r_dsr, n_dsr;
    logic [QW-1:0]   r_quo, n_quo;
    logic            fits;

    assign fits = (r_rem >= r_dsr);

    // Load operands on start, then try one shifted divisor per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_rem  = CW'(i_dividend);
            n_dsr  = CW'(i_divisor) << (QW - 1);
            n_cnt  = CntW'(QW - 1);
            n_quo  = '0;
        end else if (r_busy) begin
            n_rem = fits ? (r_rem - r_dsr) : r_rem;
            n_quo = {r_quo[QW-2:0], fits};
            n_dsr = r_dsr >> 1;
            n_cnt = r_cnt - CntW'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
        r_quo <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ----- rtl/trimmed_burst_moving_average.sv -----
// Top level of the trimmed burst moving average
// Usage:
// - Input channel (i_in_valid / o_in_ready / i_sample): one converter code per request.
//   A sample that does not close a burst leaves the sequencer in ST_IDLE, so a burst streams in
//   at one sample per cycle.
// - The sample that closes a burst starts the arithmetic: a one-bit-per-cycle divider
//   forms the trimmed mean, the ring memory is read and rewritten, and a constant
//   reciprocal multiply scales the total by 1/WINDOW_DEPTH on the way into the output
//   register. The sequencer passes through ST_MEAN_START, ST_MEAN_WAIT and ST_EMIT
//   before it returns to ST_IDLE; o_in_ready is low during that time, so no new sample
//   is taken before the block is through with the closing one.
// - Output channel (o_out_valid / i_out_ready / o_average, o_trimmed_mean): one request
//   per completed burst, held in an output register. While the receiver stalls, new
//   samples are still taken; a further closing burst waits until the register frees.
// - APB port: register 0 (address 0) is burst_len, clamped to 3..MAX_BURST in use.
// - Reset (synchronous, active low) clears the burst counters, the ring position,
//   the running total and the per-entry valid bits; the ring reads as zero until
//   written, so no clearing pass is needed. burst_len returns to 10.
`default_nettype none

module trimmed_burst_moving_average #(
    parameter int WINDOW_DEPTH = tbma_pkg::DEF_WINDOW_DEPTH,
    parameter int MAX_BURST    = tbma_pkg::DEF_MAX_BURST,
    parameter int SAMPLE_BITS  = tbma_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Sample channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [tbma_pkg::SAMPLE_W-1:0] i_sample,
    // Result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [tbma_pkg::SAMPLE_W-1:0] o_average,
    output logic      [tbma_pkg::SAMPLE_W-1:0] o_trimmed_mean,
    // Configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tbma_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [tbma_pkg::PDATA_W-1:0]  pwdata,
    output logic      [tbma_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready
);

    import tbma_pkg::*;

    localparam int SmpW   = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int CountW = $clog2(MAX_BURST + 1);
    localparam int SumW   = SmpW + CountW;
    localparam int AddrW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int TotW   = SmpW + $clog2(WINDOW_DEPTH);
    localparam int NW     = SumW;
    localparam int DW     = CountW;
    localparam int CmpW   = (CountW > LEN_W) ? CountW : LEN_W;

    // Reciprocal of the window depth, exact for every total of TotW bits
    localparam int RecL  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 0;
    localparam int RecSh = TotW + RecL;
    localparam int RecW  = TotW + 1;
    localparam int ProdW = TotW + RecW;
    localparam logic [RecW-1:0] RecipM =
        RecW'(((64'd1 << RecSh) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));

    // Control state
    t_state                  r_state, n_state;
    logic [LEN_W-1:0]        r_burst_len, n_burst_len;
    logic [CountW-1:0]       r_count, n_count;
    logic [AddrW-1:0]        r_pos, n_pos;
    logic [TotW-1:0]         r_total, n_total;
    logic [WINDOW_DEPTH-1:0] r_valid, n_valid;
    logic                    r_out_valid, n_out_valid;

    // Payload state
    logic [SumW-1:0]         r_sum, n_sum;
    logic [SmpW-1:0]         r_min, n_min;
    logic [SmpW-1:0]         r_max, n_max;
    logic [SmpW-1:0]         r_mean, n_mean;
    logic [SmpW-1:0]         r_avg, n_avg;
    logic [SmpW-1:0]         r_tmean, n_tmean;

    // Datapath helpers
    logic [SmpW-1:0]         smp;
    logic [CountW-1:0]       cnt_inc;
    logic [CmpW-1:0]         len_ext;
    logic [CountW-1:0]       eff_len;
    logic                    in_acc;
    logic                    out_acc;
    logic                    cfg_wr;
    logic [SmpW-1:0]         old_entry;
    logic [ProdW-1:0]        avg_prod;
    logic [SmpW-1:0]         avg_q;

    // Ring memory and divider hookup
    logic                    ram_wen, ram_ren;
    logic [SmpW-1:0]         ram_rdata;
    logic                    div_start, div_done;
    logic [NW-1:0]           div_dividend;
    logic [DW-1:0]           div_divisor;
    logic [SmpW-1:0]         div_quo;

    tbma_ram #(
        .WIDTH (SmpW),
        .DEPTH (WINDOW_DEPTH),
        .ADDR_W(AddrW)
    ) u_ring (
        .i_clk  (i_clk),
        .i_wen  (ram_wen),
        .i_waddr(r_pos),
        .i_wdata(div_quo),
        .i_ren  (ram_ren),
        .i_raddr(r_pos),
        .o_rdata(ram_rdata)
    );

    tbma_div #(
        .NW(NW),
        .DW(DW),
        .QW(SmpW)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(div_dividend),
        .i_divisor (div_divisor),
        .o_done    (div_done),
        .o_quotient(div_quo)
    );

    // Handshakes
    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_acc    = r_out_valid && i_out_ready;
    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite && pready &&
                        (paddr[PADDR_W-1:2] == REG_BURST_LEN);
    assign prdata     = (paddr[PADDR_W-1:2] == REG_BURST_LEN) ?
                        PDATA_W'(r_burst_len) : '0;

    // Clamp the burst length to its legal range
    assign len_ext = CmpW'(r_burst_len);
    always_comb begin
        if (len_ext > CmpW'(MAX_BURST)) begin
            eff_len = CountW'(MAX_BURST);
        end else if (len_ext < CmpW'(MIN_BURST)) begin
            eff_len = CountW'(MIN_BURST);
        end else begin
            eff_len = CountW'(len_ext);
        end
    end

    assign smp       = i_sample[SmpW-1:0];
    assign cnt_inc   = r_count + CountW'(1);
    assign old_entry = r_valid[r_pos] ? ram_rdata : '0;

    // Divider operands: trimmed sum over count-2
    assign div_dividend = NW'(r_sum - SumW'(r_min) - SumW'(r_max));
    assign div_divisor  = DW'(r_count - CountW'(TRIM_COUNT));

    // Scale the running total by the window depth
    assign avg_prod = ProdW'(r_total) * ProdW'(RecipM);
    assign avg_q    = avg_prod[RecSh +: SmpW];

    // Sequencer: accumulate, divide, update ring, scale, emit
    always_comb begin
        n_state     = r_state;
        n_burst_len = cfg_wr ? pwdata[LEN_W-1:0] : r_burst_len;
        n_count     = r_count;
        n_pos       = r_pos;
        n_total     = r_total;
        n_valid     = r_valid;
        n_out_valid = out_acc ? 1'b0 : r_out_valid;
        n_sum       = r_sum;
        n_min       = r_min;
        n_max       = r_max;
        n_mean      = r_mean;
        n_avg       = r_avg;
        n_tmean     = r_tmean;
        ram_wen     = 1'b0;
        ram_ren     = 1'b0;
        div_start   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (r_count == '0) begin
                        n_sum = SumW'(smp);
                        n_min = smp;
                        n_max = smp;
                    end else begin
                        n_sum = r_sum + SumW'(smp);
                        n_min = (smp < r_min) ? smp : r_min;
                        n_max = (smp > r_max) ? smp : r_max;
                    end
                    n_count = cnt_inc;
                    if (cnt_inc >= eff_len) begin
                        n_state = ST_MEAN_START;
                    end
                end
            end
            ST_MEAN_START: begin
                // Launch the mean and fetch the entry about to be replaced
                div_start = 1'b1;
                ram_ren   = 1'b1;
                n_count   = '0;
                n_state   = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT: begin
                if (div_done) begin
                    // Replace the oldest entry and adjust the running total
                    ram_wen        = 1'b1;
                    n_valid[r_pos] = 1'b1;
                    n_total        = r_total - TotW'(old_entry) + TotW'(div_quo);
                    n_mean         = div_quo;
                    n_pos          = (r_pos == AddrW'(WINDOW_DEPTH - 1)) ?
                                     '0 : r_pos + AddrW'(1);
                    n_state        = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_avg       = avg_q;
                    n_tmean     = r_mean;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_burst_len <= LEN_RESET;
            r_count     <= '0;
            r_pos       <= '0;
            r_total     <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_burst_len <= n_burst_len;
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_total     <= n_total;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_sum   <= n_sum;
        r_min   <= n_min;
        r_max   <= n_max;
        r_mean  <= n_mean;
        r_avg   <= n_avg;
        r_tmean <= n_tmean;
    end

    assign o_out_valid    = r_out_valid;
    assign o_average      = SAMPLE_W'(r_avg);
    assign o_trimmed_mean = SAMPLE_W'(r_tmean);

endmodule

`default_nettype wire

// ----- rtl/tbma_checker.sv -----
// Port-level checker for the trimmed burst moving average, with its bind
`default_nettype none

`include "trimmed_burst_moving_average_assert.svh"

module tbma_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_ready,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [tbma_pkg::SAMPLE_W-1:0] o_average,
    input wire logic [tbma_pkg::SAMPLE_W-1:0] o_trimmed_mean,
    input wire logic                          psel,
    input wire logic                          pready
);

    // A stalled result keeps its fields
    `TBMA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_average) && $stable(o_trimmed_mean))

    // Reset drops any pending result
    `TBMA_ASSERT_NEXT_ALWAYS(a_rst_clear, i_clk, !i_rst_n, !o_out_valid)

    // A result never appears right after a sample is taken: the divider sits between
    `TBMA_ASSERT_NEXT(a_no_fast_result, i_clk, i_rst_n, i_in_valid && o_in_ready,
        !$rose(o_out_valid))

    // The configuration port never inserts wait states
    `TBMA_ASSERT_IMPL(a_pready_high, i_clk, i_rst_n, psel, pready)

endmodule

bind trimmed_burst_moving_average tbma_checker u_tbma_checker (.*);

`default_nettype wire
